// ===== rtl/flfr_pkg.sv =====
package flfr_pkg;

    localparam int MAX_FRAME_DEF = 32;

    localparam int FL_W      = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_STATION_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN  = 2'd1;

    localparam logic [7:0]      STATION_ID_RST = 8'd1;
    localparam logic [FL_W-1:0] FRAME_LEN_RST  = 6'd9;
    localparam int              MIN_FRAME      = 5;

    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'h55;
    localparam logic [7:0] TAIL_FIRST  = 8'hA5;
    localparam logic [7:0] TAIL_SECOND = 8'h5A;

    localparam logic [2:0] ST_HUNT     = 3'd0;
    localparam logic [2:0] ST_HDR_OK   = 3'd1;
    localparam logic [2:0] ST_BODY     = 3'd2;
    localparam logic [2:0] ST_REJECT   = 3'd3;
    localparam logic [2:0] ST_BAD_TAIL = 3'd4;
    localparam logic [2:0] ST_REPLAY   = 3'd5;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic load_rep;
    } flfr_cmd_t;

    typedef struct packed {
        logic good_frame;
        logic out_free;
        logic rep_done;
    } flfr_stat_t;

endpackage

// ===== rtl/flfr_datapath.sv =====
module flfr_datapath #(
    parameter int MAX_FRAME = flfr_pkg::MAX_FRAME_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [flfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [flfr_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic [7:0]                     s_rx_byte,
    input  flfr_pkg::flfr_cmd_t            cmd,
    output flfr_pkg::flfr_stat_t           stat,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [7:0]                     m_data_byte,
    output logic [4:0]                     m_byte_index,
    output logic                           m_last
);
    import flfr_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam int AW    = $clog2(MAX_FRAME);
    localparam int CMP_W = (POS_W > FL_W) ? POS_W : FL_W;
    localparam logic [CMP_W-1:0] MIN_LEN = CMP_W'(MIN_FRAME);
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_FRAME);

    logic [7:0]       station_id_reg;
    logic [FL_W-1:0]  frame_length_reg;
    logic             in_body_reg, in_body_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [7:0]       prev_byte_reg;
    logic [7:0]       frame_mem [MAX_FRAME];
    logic [7:0]       rd_data_reg;
    logic [AW-1:0]    rep_idx_reg;
    logic [AW-1:0]    rep_last_reg;
    logic             m_valid_reg;
    logic [2:0]       m_status_reg;
    logic [7:0]       m_data_reg;
    logic [4:0]       m_index_reg;
    logic             m_last_reg;

    logic [CMP_W-1:0] fl_ext, len_cmp;
    logic [POS_W-1:0] len_eff, pos_inc;
    logic [AW-1:0]    len_m1;
    logic             wr_en, good;
    logic [2:0]       res_status;

    // Saturate the configured length to the legal range
    always_comb begin
        fl_ext = CMP_W'(frame_length_reg);
        if (fl_ext < MIN_LEN) begin
            len_cmp = MIN_LEN;
        end else if (fl_ext > MAX_LEN) begin
            len_cmp = MAX_LEN;
        end else begin
            len_cmp = fl_ext;
        end
        len_eff = POS_W'(len_cmp);
        len_m1  = AW'(len_eff - 1'b1);
        pos_inc = position_reg + 1'b1;
    end

    always_comb begin
        in_body_next  = in_body_reg;
        position_next = position_reg;
        wr_en         = 1'b0;
        good          = 1'b0;
        res_status    = ST_HUNT;
        if (!in_body_reg) begin
            if (position_reg == POS_W'(0)) begin
                if (s_rx_byte == HDR_FIRST) begin
                    wr_en         = 1'b1;
                    position_next = POS_W'(1);
                    res_status    = ST_HDR_OK;
                end
            end else if (position_reg == POS_W'(1)) begin
                wr_en = 1'b1;
                if (s_rx_byte == HDR_SECOND) begin
                    position_next = POS_W'(2);
                    res_status    = ST_HDR_OK;
                end else begin
                    position_next = POS_W'(0);
                    res_status    = ST_REJECT;
                end
            end else begin
                wr_en = 1'b1;
                if (s_rx_byte == station_id_reg) begin
                    position_next = POS_W'(3);
                    in_body_next  = 1'b1;
                    res_status    = ST_HDR_OK;
                end else begin
                    position_next = POS_W'(0);
                    res_status    = ST_REJECT;
                end
            end
        end else if (position_reg >= len_eff) begin
            // length lowered under a running frame: drop it
            in_body_next  = 1'b0;
            position_next = POS_W'(0);
            res_status    = ST_BAD_TAIL;
        end else begin
            wr_en = 1'b1;
            if (pos_inc < len_eff) begin
                position_next = pos_inc;
                res_status    = ST_BODY;
            end else begin
                in_body_next  = 1'b0;
                position_next = POS_W'(0);
                res_status    = ST_BAD_TAIL;
                good = (s_rx_byte == TAIL_SECOND) && (prev_byte_reg == TAIL_FIRST);
            end
        end
    end

    assign stat.good_frame = good;
    assign stat.out_free   = !m_valid_reg || m_ready;
    assign stat.rep_done   = (rep_idx_reg == rep_last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            station_id_reg   <= STATION_ID_RST;
            frame_length_reg <= FRAME_LEN_RST;
            in_body_reg      <= 1'b0;
            position_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_STATION_ID: station_id_reg   <= cfg_data;
                    REG_FRAME_LEN:  frame_length_reg <= cfg_data[FL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                in_body_reg  <= in_body_next;
                position_reg <= position_next;
            end
            if ((cmd.accept && !good) || cmd.load_rep) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && wr_en) begin
            frame_mem[position_reg[AW-1:0]] <= s_rx_byte;
            prev_byte_reg                   <= s_rx_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= frame_mem[rep_idx_reg];
        end
        if (cmd.accept && good) begin
            rep_idx_reg  <= '0;
            rep_last_reg <= len_m1;
        end else if (cmd.load_rep) begin
            rep_idx_reg <= rep_idx_reg + 1'b1;
        end
        if (cmd.accept && !good) begin
            m_status_reg <= res_status;
            m_data_reg   <= s_rx_byte;
            m_index_reg  <= 5'(position_reg);
            m_last_reg   <= 1'b1;
        end else if (cmd.load_rep) begin
            m_status_reg <= ST_REPLAY;
            m_data_reg   <= rd_data_reg;
            m_index_reg  <= 5'(rep_idx_reg);
            m_last_reg   <= (rep_idx_reg == rep_last_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_data_byte  = m_data_reg;
    assign m_byte_index = m_index_reg;
    assign m_last       = m_last_reg;

endmodule

// ===== rtl/flfr_ctrl.sv =====
module flfr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  flfr_pkg::flfr_stat_t  stat,
    output flfr_pkg::flfr_cmd_t   cmd
);
    import flfr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;

    assign s_ready      = (state_reg == S_IDLE) && stat.out_free;
    assign cmd.accept   = s_valid && s_ready;
    assign cmd.rd_issue = (state_reg == S_RD);
    assign cmd.load_rep = (state_reg == S_LOAD) && stat.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.accept && stat.good_frame) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                // hold until the output register frees up
                if (stat.out_free) begin
                    state_next = stat.rep_done ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/fixed_length_frame_receiver_top.sv =====
// Channel  Direction  Handshake              Payload
// s_       in         s_valid / s_ready      s_rx_byte
// m_       out        m_valid / m_ready      m_status, m_data_byte, m_byte_index, m_last
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte's result is registered onto m_ the cycle after acceptance; the next byte
// is taken once the output register is free.
// A good frame replays byte by byte, each read from the frame memory into a
// register (S_RD), then loaded out (S_LOAD); no input is taken during replay.
// Reset (aresetn, synchronous): station_id 1, frame_length 9, hunting.
// A stalled m_ready holds the result and stalls the input side.
module fixed_length_frame_receiver_top #(
    parameter int MAX_FRAME = flfr_pkg::MAX_FRAME_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [7:0]                     m_data_byte,
    output logic [4:0]                     m_byte_index,
    output logic                           m_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [flfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [flfr_pkg::CFG_DAT_W-1:0] cfg_data
);
    import flfr_pkg::*;

    flfr_cmd_t  cmd;
    flfr_stat_t stat;

    assign cfg_ready = 1'b1;

    flfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    flfr_datapath #(
        .MAX_FRAME (MAX_FRAME)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_rx_byte    (s_rx_byte),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last)
    );

`ifndef SYNTHESIS
    // only replay results leave last low
    a_last_low_only_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_status == ST_REPLAY))
        else $error("non-final result outside replay");

    // an input is taken only when its result has room
    a_accept_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!m_valid || m_ready))
        else $error("input accepted while output register busy");

    // input side is open while the final replay request goes out
    a_ready_after_replay: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last && (m_status == ST_REPLAY)) |-> s_ready)
        else $error("input not ready when replay finished");
`endif

endmodule

// ===== dv/fixed_length_frame_receiver_top_tb.sv =====
`timescale 1ns / 100ps

module fixed_length_frame_receiver_top_tb;
    import flfr_pkg::*;

    localparam int unsigned FRAME_SLOTS   = MAX_FRAME_DEF;
    localparam int unsigned DRAIN_CYCLES  = 6;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned MAX_ERR_PRINT = 10;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] data_byte;
        logic [4:0] byte_index;
        logic       last;
    } frame_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [2:0]           m_status;
    logic [7:0]           m_data_byte;
    logic [4:0]           m_byte_index;
    logic                 m_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    // receiver state as predicted
    logic [7:0]      station_q = STATION_ID_RST;
    logic [FL_W-1:0] length_q  = FRAME_LEN_RST;
    logic            body_q    = 1'b0;
    int unsigned     pos_q     = 0;
    logic [7:0]      frame_mem [FRAME_SLOTS];

    frame_result_t pending_results [$];
    int unsigned   error_count = 0;
    int unsigned   items_sent  = 0;
    int unsigned   cycle_count = 0;
    int unsigned   stall_left  = 0;
    bit            idling      = 1'b1;

    fixed_length_frame_receiver_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_data_byte  (m_data_byte),
        .m_byte_index (m_byte_index),
        .m_last       (m_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall bursts while idling is set
    always @(negedge aclk) begin
        if (stall_left == 0 && idling && $urandom_range(0, 3) == 0)
            stall_left = $urandom_range(1, 5);
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.status     = m_status;
            got.data_byte  = m_data_byte;
            got.byte_index = m_byte_index;
            got.last       = m_last;
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_ERR_PRINT)
                    $display("%0t: unexpected result st=%0d data=%h idx=%0d last=%b",
                             $time, got.status, got.data_byte, got.byte_index, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.data_byte != want.data_byte ||
                    got.byte_index != want.byte_index || got.last != want.last) begin
                    error_count++;
                    if (error_count <= MAX_ERR_PRINT)
                        $display("%0t: want st=%0d d=%h i=%0d l=%b got st=%0d d=%h i=%0d l=%b",
                                 $time, want.status, want.data_byte, want.byte_index,
                                 want.last, got.status, got.data_byte, got.byte_index,
                                 got.last);
                end
            end
        end
    end

    function automatic int unsigned capped_length();
        int unsigned n;
        n = length_q;
        if (n < MIN_FRAME) n = MIN_FRAME;
        if (n > FRAME_SLOTS) n = FRAME_SLOTS;
        return n;
    endfunction

    function automatic void queue_result(input logic [2:0] st, input logic [7:0] b,
                                         input int unsigned idx, input logic lst);
        frame_result_t r;
        r.status     = st;
        r.data_byte  = b;
        r.byte_index = idx[4:0];
        r.last       = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void predict_byte(input logic [7:0] b);
        int unsigned len;
        int unsigned at;
        len = capped_length();
        at  = pos_q;
        if (!body_q) begin
            if (at == 0) begin
                if (b != HDR_FIRST) begin
                    queue_result(ST_HUNT, b, 0, 1'b1);
                end else begin
                    frame_mem[0] = b;
                    pos_q = 1;
                    queue_result(ST_HDR_OK, b, 0, 1'b1);
                end
            end else if (at == 1) begin
                frame_mem[1] = b;
                if (b != HDR_SECOND) begin
                    pos_q = 0;
                    queue_result(ST_REJECT, b, 1, 1'b1);
                end else begin
                    pos_q = 2;
                    queue_result(ST_HDR_OK, b, 1, 1'b1);
                end
            end else begin
                frame_mem[2] = b;
                if (b != station_q) begin
                    pos_q = 0;
                    queue_result(ST_REJECT, b, 2, 1'b1);
                end else begin
                    pos_q  = 3;
                    body_q = 1'b1;
                    queue_result(ST_HDR_OK, b, 2, 1'b1);
                end
            end
        end else if (at >= len) begin
            // length dropped below the fill level: drop the frame
            body_q = 1'b0;
            pos_q  = 0;
            queue_result(ST_BAD_TAIL, b, at, 1'b1);
        end else begin
            frame_mem[at % FRAME_SLOTS] = b;
            pos_q = at + 1;
            if (pos_q < len) begin
                queue_result(ST_BODY, b, at, 1'b1);
            end else begin
                body_q = 1'b0;
                pos_q  = 0;
                if (frame_mem[len-1] == TAIL_SECOND && frame_mem[len-2] == TAIL_FIRST) begin
                    for (int unsigned i = 0; i < len; i++)
                        queue_result(ST_REPLAY, frame_mem[i], i, i + 1 == len);
                end else begin
                    queue_result(ST_BAD_TAIL, b, at, 1'b1);
                end
            end
        end
    endfunction

    // Leaves s_valid high after acceptance; drain lowers it.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        predict_byte(b);
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] seq [$]);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_STATION_ID) station_q = val;
        else if (idx == REG_FRAME_LEN) length_q = val[FL_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly well-formed frames with random body; some flawed, some noise.
    task automatic run_frames(input int unsigned budget);
        int unsigned stop_at;
        int unsigned len;
        int unsigned flaw_at;
        logic [7:0]  b;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            len     = capped_length();
            flaw_at = len;
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0: flaw_at = 0;
                    1: flaw_at = 1;
                    2: flaw_at = 2;
                    3: flaw_at = len - 2;
                    default: flaw_at = len - 1;
                endcase
            end
            for (int unsigned i = 0; i < len && items_sent < stop_at; i++) begin
                if (i == 0) b = HDR_FIRST;
                else if (i == 1) b = HDR_SECOND;
                else if (i == 2) b = station_q;
                else if (i == len - 1) b = TAIL_SECOND;
                else if (i == len - 2) b = TAIL_FIRST;
                else b = 8'($urandom);
                if (i == flaw_at) b = b ^ 8'($urandom_range(1, 255));
                send_byte(b);
            end
        end
    endtask

    task automatic test_hunt_noise();
        send_bytes('{8'h00, 8'hFF});
        drain();
    endtask

    task automatic test_reset_frame();
        // reset config: station 1, nine bytes per frame
        send_bytes('{HDR_FIRST, HDR_SECOND, 8'h01, 8'hFF, 8'h00, 8'h80, 8'h7F,
                     TAIL_FIRST, TAIL_SECOND});
        drain();
    endtask

    task automatic test_header_reject();
        send_bytes('{HDR_FIRST, 8'h00});
        send_bytes('{HDR_FIRST, HDR_SECOND, 8'h02});
        drain();
    endtask

    task automatic test_short_frames();
        // length 0 saturates to the minimum frame
        write_reg(REG_STATION_ID, 8'hFF);
        write_reg(REG_FRAME_LEN, 8'h00);
        send_bytes('{HDR_FIRST, HDR_SECOND, 8'hFF, TAIL_FIRST, TAIL_SECOND});
        send_bytes('{HDR_FIRST, HDR_SECOND, 8'hFF, 8'h00, TAIL_SECOND});
        drain();
    endtask

    task automatic test_length_lowered();
        write_reg(REG_FRAME_LEN, 8'd9);
        write_reg(REG_SPARE_A, 8'($urandom));
        write_reg(REG_SPARE_B, 8'($urandom));
        send_bytes('{HDR_FIRST, HDR_SECOND, 8'hFF, 8'h80, 8'h7F});
        drain();
        // cut the frame short while it is half stored
        write_reg(REG_FRAME_LEN, 8'd5);
        send_byte(8'h01);
        drain();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 7; p++) begin
            drain();
            idling = (p != 3);
            case (p)
                0: begin
                    write_reg(REG_STATION_ID, 8'($urandom));
                    write_reg(REG_FRAME_LEN, {2'($urandom), 6'd5});
                end
                1: begin
                    write_reg(REG_STATION_ID, 8'h00);
                    write_reg(REG_FRAME_LEN, 8'hFF);
                end
                2: begin
                    write_reg(REG_STATION_ID, 8'hFF);
                    write_reg(REG_FRAME_LEN, 8'd4);
                end
                3: begin
                    write_reg(REG_STATION_ID, 8'($urandom));
                    write_reg(REG_FRAME_LEN, 8'd32);
                end
                4: begin
                    write_reg(REG_STATION_ID, 8'($urandom));
                    write_reg(REG_FRAME_LEN, 8'($urandom));
                    write_reg(REG_SPARE_B, 8'($urandom));
                end
                5: begin
                    write_reg(REG_STATION_ID, 8'($urandom));
                    write_reg(REG_FRAME_LEN, {2'($urandom), 6'($urandom_range(5, 12))});
                end
                default: begin
                    write_reg(REG_SPARE_A, 8'($urandom));
                    write_reg(REG_STATION_ID, 8'($urandom));
                    write_reg(REG_FRAME_LEN, 8'd9);
                end
            endcase
            run_frames((p == 1 || p == 3) ? 70 : 55);
        end
        drain();
    endtask

    task automatic test_no_idle();
        idling = 1'b0;
        write_reg(REG_STATION_ID, 8'($urandom));
        write_reg(REG_FRAME_LEN, 8'($urandom_range(5, 9)));
        run_frames(45);
        drain();
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_hunt_noise();
        test_reset_frame();
        test_header_reject();
        test_short_frames();
        test_length_lowered();
        test_random_phases();
        test_no_idle();

        if (error_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
